// File: src/nbody_gravity_step_assert.svh
// Assertion macros for the n-body gravity step checker.
// Needs signals named clk and rst in the scope where a macro is used.
`ifndef NBODY_GRAVITY_STEP_ASSERT_SVH
`define NBODY_GRAVITY_STEP_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define NBG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion lbl failed");

// The consequent must hold in the same cycle as the antecedent.
`define NBG_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion lbl failed");

`endif

// File: src/nbg_pkg.sv
// Shared constants and types for the n-body gravity step.
// Used by every module of the block; depends on nothing.
package nbg_pkg;

  localparam int MAX_BODIES = 64;
  localparam int FRAC_BITS  = 16;
  localparam int IDX_W      = $clog2(MAX_BODIES);
  localparam int CNT_W      = 7;
  localparam int K_SHIFT    = 3 * FRAC_BITS - 24;
  localparam int NUM_W      = (64 + K_SHIFT > 96) ? 64 + K_SHIFT : 96;
  localparam int DIV_CNT_W  = $clog2(NUM_W + 1);
  localparam int SUM_W      = 34 + IDX_W;
  localparam int SQRT_STEPS = 32;

  localparam logic REG_BODY_COUNT = 1'b0;
  localparam logic REG_GRAV_CONST = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE, OP_WRITE, OP_RD_I, OP_LAT_I, OP_RD_J, OP_LAT_J, OP_SQ1, OP_SQ2,
    OP_KMUL, OP_SQRT, OP_DIV1, OP_DIV2, OP_MXL, OP_MXH, OP_DIVX, OP_ACCX,
    OP_MYL, OP_MYH, OP_DIVY, OP_ACCY, OP_NV, OP_RD_P, OP_UPD
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [IDX_W-1:0] idx_i;
    logic [IDX_W-1:0] idx_j;
    logic             last;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic sqrt_busy;
    logic skip_j;
    logic pulled_i;
    logic out_valid;
  } dp_status_t;

endpackage

// File: src/nbg_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nbg_pkg for the numerator width.
module nbg_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [nbg_pkg::NUM_W-1:0] num,
  input  logic [32:0]              den,
  output logic                     busy,
  output logic [nbg_pkg::NUM_W-1:0] quot
);
  import nbg_pkg::*;

  logic [NUM_W-1:0]     nq;
  logic [32:0]          rem;
  logic [DIV_CNT_W-1:0] cnt;
  logic [33:0]          rem_sh;
  logic [33:0]          diff;
  logic                 ge;

  assign rem_sh = {rem, nq[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den};
  assign ge     = rem_sh >= {1'b0, den};
  assign busy   = cnt != '0;
  assign quot   = nq;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= DIV_CNT_W'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nq  <= num;
      rem <= '0;
    end else if (busy) begin
      nq  <= {nq[NUM_W-2:0], ge};
      rem <= ge ? diff[32:0] : rem_sh[32:0];
    end
  end

endmodule

// File: src/nbg_sqrt.sv
// Digit-by-digit integer square root of a 64-bit value, one root bit per cycle.
// Depends on nbg_pkg for the step count.
module nbg_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] rad,
  output logic        busy,
  output logic [31:0] root
);
  import nbg_pkg::*;

  logic [63:0] x;
  logic [33:0] rem;
  logic [5:0]  cnt;
  logic [35:0] rem_t;
  logic [35:0] trial;
  logic        ge;

  assign rem_t = {rem, x[63:62]};
  assign trial = {2'b00, root, 2'b01};
  assign ge    = rem_t >= trial;
  assign busy  = cnt != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= 6'(SQRT_STEPS);
    end else if (busy) begin
      cnt <= cnt - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= rad;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      x    <= {x[61:0], 2'b00};
      rem  <= ge ? 34'(rem_t - trial) : rem_t[33:0];
      root <= {root[30:0], ge};
    end
  end

endmodule

// File: src/nbg_datapath.sv
// Datapath: body table memories, pair force arithmetic, sums and result register.
// Depends on nbg_pkg, nbg_div and nbg_sqrt; driven by commands from nbg_ctrl.
module nbg_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  nbg_pkg::dp_cmd_t      cmd,
  output nbg_pkg::dp_status_t   status,
  input  logic [31:0]           grav_const,
  input  logic [5:0]            body_index,
  input  logic signed [31:0]    pos_x,
  input  logic signed [31:0]    pos_y,
  input  logic signed [31:0]    vel_x,
  input  logic signed [31:0]    vel_y,
  input  logic [31:0]           mass,
  input  logic                  pulled_flag,
  input  logic                  pulls_flag,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [5:0]            out_index,
  output logic signed [31:0]    new_pos_x,
  output logic signed [31:0]    new_pos_y,
  output logic signed [31:0]    new_vel_x,
  output logic signed [31:0]    new_vel_y,
  output logic                  last
);
  import nbg_pkg::*;

  function automatic logic [31:0] sat32(input logic signed [47:0] v);
    if (v > 48'sd2147483647) return 32'h7fff_ffff;
    else if (v < -48'sd2147483648) return 32'h8000_0000;
    else return v[31:0];
  endfunction

  logic [31:0] mem_px [MAX_BODIES];
  logic [31:0] mem_py [MAX_BODIES];
  logic [31:0] mem_vx [MAX_BODIES];
  logic [31:0] mem_vy [MAX_BODIES];
  logic [31:0] mem_m  [MAX_BODIES];
  logic        mem_pd [MAX_BODIES];
  logic        mem_ps [MAX_BODIES];

  logic [31:0] rd_px, rd_py, rd_vx, rd_vy, rd_m;
  logic        rd_pd, rd_ps;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_idx;
  logic        wr_ok;

  logic [31:0] xi, yi, vxi, vyi;
  logic [32:0] ax, ay;
  logic        neg_x, neg_y, sh;
  logic [31:0] bx, by, mj;
  logic [63:0] s, k;
  logic [62:0] f_reg;
  logic [NUM_W-1:0] acc;
  logic signed [SUM_W-1:0] sx, sy;

  logic signed [32:0] dx_w, dy_w;
  logic [32:0] ax_w, ay_w;
  logic        sh_w;
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] prod;
  logic [62:0] f_w;
  logic [32:0] a_w;
  logic [32:0] r_w;
  logic [31:0] root;
  logic [NUM_W-1:0] quot, div_num;
  logic        div_busy, sqrt_busy;
  logic [31:0] npx_w, npy_w;

  assign wr_idx = body_index[IDX_W-1:0];
  assign wr_ok  = {1'b0, body_index} < 7'(MAX_BODIES);
  assign rd_addr = (cmd.op == OP_RD_J) ? cmd.idx_j : cmd.idx_i;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_WRITE && wr_ok) begin
      mem_m[wr_idx]  <= mass;
      mem_pd[wr_idx] <= pulled_flag;
      mem_ps[wr_idx] <= pulls_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_WRITE && wr_ok) begin
      mem_px[wr_idx] <= pos_x;
      mem_py[wr_idx] <= pos_y;
    end else if (cmd.op == OP_UPD) begin
      mem_px[cmd.idx_i] <= npx_w;
      mem_py[cmd.idx_i] <= npy_w;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_WRITE && wr_ok) begin
      mem_vx[wr_idx] <= vel_x;
      mem_vy[wr_idx] <= vel_y;
    end else if (cmd.op == OP_NV) begin
      mem_vx[cmd.idx_i] <= sat32(48'(signed'(vxi)) + 48'(sx));
      mem_vy[cmd.idx_i] <= sat32(48'(signed'(vyi)) + 48'(sy));
    end
  end

  always_ff @(posedge clk) begin
    rd_px <= mem_px[rd_addr];
    rd_py <= mem_py[rd_addr];
    rd_vx <= mem_vx[rd_addr];
    rd_vy <= mem_vy[rd_addr];
    rd_m  <= mem_m[rd_addr];
    rd_pd <= mem_pd[rd_addr];
    rd_ps <= mem_ps[rd_addr];
  end

  assign dx_w = $signed({rd_px[31], rd_px}) - $signed({xi[31], xi});
  assign dy_w = $signed({rd_py[31], rd_py}) - $signed({yi[31], yi});
  assign ax_w = dx_w[32] ? 33'(-dx_w) : 33'(dx_w);
  assign ay_w = dy_w[32] ? 33'(-dy_w) : 33'(dy_w);
  assign sh_w = ax_w[32] | ax_w[31] | ay_w[32] | ay_w[31];

  always_comb begin
    mul_a = {1'b0, bx};
    mul_b = bx;
    unique case (cmd.op)
      OP_SQ2:  begin mul_a = {1'b0, by};         mul_b = by;                    end
      OP_KMUL: begin mul_a = {1'b0, grav_const}; mul_b = mj;                    end
      OP_MXL:  begin mul_a = ax;                 mul_b = f_w[31:0];             end
      OP_MXH:  begin mul_a = ax;                 mul_b = {1'b0, f_reg[62:32]};  end
      OP_MYL:  begin mul_a = ay;                 mul_b = f_reg[31:0];           end
      OP_MYH:  begin mul_a = ay;                 mul_b = {1'b0, f_reg[62:32]};  end
      default: begin mul_a = {1'b0, bx};         mul_b = bx;                    end
    endcase
  end

  assign prod = 65'(mul_a) * 65'(mul_b);

  assign f_w = (|quot[NUM_W-1:63]) ? {63{1'b1}} : quot[62:0];
  assign a_w = ((|quot[NUM_W-1:33]) || (quot[32:0] > 33'h1_0000_0000))
             ? 33'h1_0000_0000 : quot[32:0];
  assign r_w = sh ? {root, 1'b0} : {1'b0, root};

  always_comb begin
    unique case (cmd.op)
      OP_DIV1: div_num = NUM_W'(k) << K_SHIFT;
      OP_DIV2: div_num = quot;
      default: div_num = acc;
    endcase
  end

  nbg_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.op == OP_SQRT),
    .rad   (s),
    .busy  (sqrt_busy),
    .root  (root)
  );

  nbg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.op == OP_DIV1 || cmd.op == OP_DIV2 || cmd.op == OP_DIVX ||
            cmd.op == OP_DIVY),
    .num   (div_num),
    .den   (r_w),
    .busy  (div_busy),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    unique case (cmd.op) inside
      OP_LAT_I: begin
        xi  <= rd_px;
        yi  <= rd_py;
        vxi <= rd_vx;
        vyi <= rd_vy;
        sx  <= '0;
        sy  <= '0;
      end
      OP_LAT_J: begin
        ax    <= ax_w;
        ay    <= ay_w;
        neg_x <= dx_w[32];
        neg_y <= dy_w[32];
        sh    <= sh_w;
        bx    <= sh_w ? ax_w[32:1] : ax_w[31:0];
        by    <= sh_w ? ay_w[32:1] : ay_w[31:0];
        mj    <= rd_m;
      end
      OP_SQ1:  s <= prod[63:0];
      OP_SQ2:  s <= s + prod[63:0];
      OP_KMUL: k <= prod[63:0];
      OP_MXL: begin
        f_reg <= f_w;
        acc   <= NUM_W'(prod);
      end
      OP_MYL:  acc <= NUM_W'(prod);
      OP_MXH, OP_MYH: acc <= acc + (NUM_W'(prod) << 32);
      OP_ACCX: sx <= neg_x ? sx - SUM_W'(a_w) : sx + SUM_W'(a_w);
      OP_ACCY: sy <= neg_y ? sy - SUM_W'(a_w) : sy + SUM_W'(a_w);
      default: begin
      end
    endcase
  end

  assign npx_w = sat32(48'(signed'(rd_px)) + 48'(signed'(rd_vx)));
  assign npy_w = sat32(48'(signed'(rd_py)) + 48'(signed'(rd_vy)));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_UPD) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_UPD) begin
      out_index <= 6'(cmd.idx_i);
      new_pos_x <= npx_w;
      new_pos_y <= npy_w;
      new_vel_x <= rd_vx;
      new_vel_y <= rd_vy;
      last      <= cmd.last;
    end
  end

  assign status.div_busy  = div_busy;
  assign status.sqrt_busy = sqrt_busy;
  assign status.skip_j    = (cmd.idx_j == cmd.idx_i) || !rd_ps ||
                            (dx_w == '0 && dy_w == '0);
  assign status.pulled_i  = rd_pd;
  assign status.out_valid = out_valid;

endmodule

// File: src/nbg_ctrl.sv
// Controller state machine: walks bodies and pairs and sequences the datapath.
// Depends on nbg_pkg for the command and status types.
module nbg_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        mode,
  input  logic [nbg_pkg::CNT_W-1:0]   body_count,
  input  nbg_pkg::dp_status_t         status,
  output nbg_pkg::dp_cmd_t            cmd
);
  import nbg_pkg::*;

  localparam int NS = 29;

  typedef enum logic [NS-1:0] {
    S_IDLE   = NS'(1) << 0,  S_RD_I   = NS'(1) << 1,  S_LAT_I  = NS'(1) << 2,
    S_RD_J   = NS'(1) << 3,  S_LAT_J  = NS'(1) << 4,  S_SQ1    = NS'(1) << 5,
    S_SQ2    = NS'(1) << 6,  S_KMUL   = NS'(1) << 7,  S_SQRT   = NS'(1) << 8,
    S_W_SQRT = NS'(1) << 9,  S_DIV1   = NS'(1) << 10, S_W_DIV1 = NS'(1) << 11,
    S_DIV2   = NS'(1) << 12, S_W_DIV2 = NS'(1) << 13, S_MXL    = NS'(1) << 14,
    S_MXH    = NS'(1) << 15, S_DIVX   = NS'(1) << 16, S_W_DIVX = NS'(1) << 17,
    S_ACCX   = NS'(1) << 18, S_MYL    = NS'(1) << 19, S_MYH    = NS'(1) << 20,
    S_DIVY   = NS'(1) << 21, S_W_DIVY = NS'(1) << 22, S_ACCY   = NS'(1) << 23,
    S_J_NEXT = NS'(1) << 24, S_NV     = NS'(1) << 25, S_RD_P   = NS'(1) << 26,
    S_UPD    = NS'(1) << 27, S_EMIT   = NS'(1) << 28
  } state_t;

  state_t           state, state_next;
  logic [IDX_W-1:0] i, i_next, j, j_next;
  logic [CNT_W-1:0] n, n_next, n_clip;
  logic             i_last, j_last;

  assign n_clip = (body_count > CNT_W'(MAX_BODIES)) ? CNT_W'(MAX_BODIES) : body_count;
  assign i_last = (CNT_W'(i) == n - CNT_W'(1));
  assign j_last = (CNT_W'(j) == n - CNT_W'(1));
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    i_next     = i;
    j_next     = j;
    n_next     = n;
    cmd.op     = OP_NONE;
    cmd.idx_i  = i;
    cmd.idx_j  = j;
    cmd.last   = i_last;
    unique case (state)
      S_IDLE: begin
        if (in_valid && !mode) begin
          cmd.op = OP_WRITE;
        end else if (in_valid && n_clip != '0) begin
          n_next     = n_clip;
          i_next     = '0;
          state_next = S_RD_I;
        end
      end
      S_RD_I: begin cmd.op = OP_RD_I; state_next = S_LAT_I; end
      S_LAT_I: begin
        cmd.op     = OP_LAT_I;
        j_next     = '0;
        state_next = status.pulled_i ? S_RD_J : S_NV;
      end
      S_RD_J: begin cmd.op = OP_RD_J; state_next = S_LAT_J; end
      S_LAT_J: begin
        cmd.op     = OP_LAT_J;
        state_next = status.skip_j ? S_J_NEXT : S_SQ1;
      end
      S_SQ1:  begin cmd.op = OP_SQ1;  state_next = S_SQ2;    end
      S_SQ2:  begin cmd.op = OP_SQ2;  state_next = S_KMUL;   end
      S_KMUL: begin cmd.op = OP_KMUL; state_next = S_SQRT;   end
      S_SQRT: begin cmd.op = OP_SQRT; state_next = S_W_SQRT; end
      S_W_SQRT: if (!status.sqrt_busy) state_next = S_DIV1;
      S_DIV1: begin cmd.op = OP_DIV1; state_next = S_W_DIV1; end
      S_W_DIV1: if (!status.div_busy) state_next = S_DIV2;
      S_DIV2: begin cmd.op = OP_DIV2; state_next = S_W_DIV2; end
      S_W_DIV2: if (!status.div_busy) state_next = S_MXL;
      S_MXL:  begin cmd.op = OP_MXL;  state_next = S_MXH;    end
      S_MXH:  begin cmd.op = OP_MXH;  state_next = S_DIVX;   end
      S_DIVX: begin cmd.op = OP_DIVX; state_next = S_W_DIVX; end
      S_W_DIVX: if (!status.div_busy) state_next = S_ACCX;
      S_ACCX: begin cmd.op = OP_ACCX; state_next = S_MYL;    end
      S_MYL:  begin cmd.op = OP_MYL;  state_next = S_MYH;    end
      S_MYH:  begin cmd.op = OP_MYH;  state_next = S_DIVY;   end
      S_DIVY: begin cmd.op = OP_DIVY; state_next = S_W_DIVY; end
      S_W_DIVY: if (!status.div_busy) state_next = S_ACCY;
      S_ACCY: begin cmd.op = OP_ACCY; state_next = S_J_NEXT; end
      S_J_NEXT: begin
        if (j_last) begin
          state_next = S_NV;
        end else begin
          j_next     = j + IDX_W'(1);
          state_next = S_RD_J;
        end
      end
      S_NV: begin
        cmd.op = OP_NV;
        if (i_last) begin
          i_next     = '0;
          state_next = S_RD_P;
        end else begin
          i_next     = i + IDX_W'(1);
          state_next = S_RD_I;
        end
      end
      S_RD_P: begin cmd.op = OP_RD_I; state_next = S_UPD; end
      S_UPD:  begin cmd.op = OP_UPD;  state_next = S_EMIT; end
      S_EMIT: begin
        if (!status.out_valid) begin
          if (i_last) begin
            state_next = S_IDLE;
          end else begin
            i_next     = i + IDX_W'(1);
            state_next = S_RD_P;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      i     <= '0;
      j     <= '0;
      n     <= '0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
      n     <= n_next;
    end
  end

endmodule

// File: src/nbg_cfg.sv
// Configuration registers behind the APB-style port: body count and G.
// Depends on nbg_pkg for register indexes.
module nbg_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic [nbg_pkg::CNT_W-1:0] body_count,
  output logic [31:0]               grav_const
);
  import nbg_pkg::*;

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      body_count <= '0;
      grav_const <= 32'd1;
    end else if (wr) begin
      unique case (paddr[2])
        REG_BODY_COUNT: body_count <= pwdata[CNT_W-1:0];
        REG_GRAV_CONST: grav_const <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BODY_COUNT: prdata = 32'(body_count);
      REG_GRAV_CONST: prdata = grav_const;
      default:        prdata = '0;
    endcase
  end

endmodule

// File: src/nbody_gravity_step.sv
// Top level of the direct 2D n-body gravity step.
// Depends on nbg_pkg, nbg_cfg, nbg_ctrl and nbg_datapath.
//
// Input channel (in_valid/in_stall): mode 0 stores one body entry; mode 1 runs one
// tick over entries 0 to min(body_count, 64)-1.
// Output channel (out_valid/out_stall): one transaction per body in index order
// after the tick, last set on the final one. A tick with body_count zero gives none.
// A tick computes a force for every ordered pair of distinct bodies where the first
// is pulled, the second pulls and the two lie apart, updates each body's velocity
// after its pairs, then updates each position and emits it as a result. Each pair
// goes through the shared bit-serial divider (four 96-step divisions) and the
// 32-step square root unit.
// in_stall stays high from the accepted tick until the cycle after the last result
// is taken. A stalled result holds; the block waits and loses nothing.
// Reset sets body_count to 0 and grav_const to 1; the table holds unknown
// values until written. Write the registers only while the block is idle.
module nbody_gravity_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               mode,
  input  logic [5:0]         body_index,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic [31:0]        mass,
  input  logic               pulled_flag,
  input  logic               pulls_flag,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         out_index,
  output logic signed [31:0] new_pos_x,
  output logic signed [31:0] new_pos_y,
  output logic signed [31:0] new_vel_x,
  output logic signed [31:0] new_vel_y,
  output logic               last
);
  import nbg_pkg::*;

  logic [CNT_W-1:0] body_count;
  logic [31:0]      grav_const;
  dp_cmd_t          cmd;
  dp_status_t       status;

  nbg_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .body_count (body_count),
    .grav_const (grav_const)
  );

  nbg_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .body_count (body_count),
    .status     (status),
    .cmd        (cmd)
  );

  nbg_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .grav_const  (grav_const),
    .body_index  (body_index),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .vel_x       (vel_x),
    .vel_y       (vel_y),
    .mass        (mass),
    .pulled_flag (pulled_flag),
    .pulls_flag  (pulls_flag),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_index   (out_index),
    .new_pos_x   (new_pos_x),
    .new_pos_y   (new_pos_y),
    .new_vel_x   (new_vel_x),
    .new_vel_y   (new_vel_y),
    .last        (last)
  );

endmodule

// File: src/nbg_checker.sv
// Port-level checker for the n-body gravity step, bound to the top level.
// Depends on the assertion macros in nbody_gravity_step_assert.svh.
`include "nbody_gravity_step_assert.svh"

module nbg_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               mode,
  input logic               out_valid,
  input logic               out_stall,
  input logic [5:0]         out_index,
  input logic signed [31:0] new_pos_x,
  input logic               last
);

  // A stalled result stays on the port unchanged.
  `NBG_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(out_index) && $stable(new_pos_x))
  // No new item is taken while a result is on offer.
  `NBG_ASSERT_SAME(a_busy_out, out_valid, in_stall)
  // A body write leaves the block idle and produces nothing.
  `NBG_ASSERT_NEXT(a_write_quiet, in_valid && !in_stall && !mode,
                   !out_valid && !in_stall)
  // After a result that is not the last, the tick is still running.
  `NBG_ASSERT_NEXT(a_more_follow, out_valid && !out_stall && !last,
                   in_stall && !out_valid)

endmodule

bind nbody_gravity_step nbg_checker u_nbg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .mode      (mode),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_index (out_index),
  .new_pos_x (new_pos_x),
  .last      (last)
);

// File: test/tb_nbody_gravity_step.sv
// Self-checking testbench for nbody_gravity_step: body table writes and ticks,
// checked against a bit-exact gravity predictor inside a small scoreboard class.
// Depends on nbg_pkg and the nbody_gravity_step RTL.
module tb_nbody_gravity_step;
  import nbg_pkg::*;

  typedef struct {
    logic              mode;
    logic [5:0]        index;
    logic [31:0]       px, py, vx, vy, mass;
    logic              pulled, pulls;
  } body_item_t;

  typedef struct {
    logic [5:0]  index;
    logic [31:0] px, py, vx, vy;
    logic        last;
  } body_state_t;

  class gravity_scoreboard;
    logic [31:0] tpx[MAX_BODIES], tpy[MAX_BODIES], tvx[MAX_BODIES], tvy[MAX_BODIES];
    logic [31:0] tmass[MAX_BODIES];
    logic        tpulled[MAX_BODIES], tpulls[MAX_BODIES];
    bit          written[MAX_BODIES];
    logic [6:0]  count;
    logic [31:0] grav;
    body_state_t pending[$];
    int          errors;

    function new();
      count = 0;
      grav = 1;
      errors = 0;
      foreach (written[i]) written[i] = 0;
    endfunction

    function void set_reg(int addr, logic [31:0] value);
      if (addr == int'(REG_BODY_COUNT)) count = value[6:0];
      else grav = value;
    endfunction

    function int active();
      return (count > MAX_BODIES) ? MAX_BODIES : int'(count);
    endfunction

    function logic [63:0] root64(logic [63:0] s);
      logic [63:0] res, one;
      res = 0;
      one = 64'd1 << 62;
      while (one > s) one = one >> 2;
      while (one != 0) begin
        if (s >= res + one) begin
          s = s - (res + one);
          res = (res >> 1) + one;
        end else begin
          res = res >> 1;
        end
        one = one >> 2;
      end
      return res;
    endfunction

    function logic [31:0] sat32(longint x);
      if (x > 64'sd2147483647) return 32'h7fffffff;
      if (x < -64'sd2147483648) return 32'h80000000;
      return x[31:0];
    endfunction

    function void pull(int i, int j, inout longint sx, inout longint sy);
      longint dx, dy;
      logic [63:0] ax, ay, bx, by, s, r, k, f, qx, qy;
      logic [127:0] t;
      int sh;
      dx = longint'(signed'(tpx[j])) - longint'(signed'(tpx[i]));
      dy = longint'(signed'(tpy[j])) - longint'(signed'(tpy[i]));
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      sh = (ax >= 64'h80000000 || ay >= 64'h80000000) ? 1 : 0;
      bx = ax >> sh;
      by = ay >> sh;
      s = bx * bx + by * by;
      if (s == 0) return;
      r = root64(s) << sh;
      k = 64'(grav) * 64'(tmass[j]);
      t = 128'(k) << K_SHIFT;
      t = t / 128'(r);
      t = t / 128'(r);
      f = (t > 128'h7fffffffffffffff) ? 64'h7fffffffffffffff : t[63:0];
      t = (128'(f) * 128'(ax)) / 128'(r);
      qx = (t > 128'h100000000) ? 64'h100000000 : t[63:0];
      t = (128'(f) * 128'(ay)) / 128'(r);
      qy = (t > 128'h100000000) ? 64'h100000000 : t[63:0];
      sx += dx < 0 ? -longint'(qx) : longint'(qx);
      sy += dy < 0 ? -longint'(qy) : longint'(qy);
    endfunction

    function void note_item(body_item_t it);
      logic [31:0] nvx[MAX_BODIES], nvy[MAX_BODIES];
      longint sx, sy;
      int n;
      body_state_t st;
      if (it.mode == 1'b0) begin
        tpx[it.index] = it.px;
        tpy[it.index] = it.py;
        tvx[it.index] = it.vx;
        tvy[it.index] = it.vy;
        tmass[it.index] = it.mass;
        tpulled[it.index] = it.pulled;
        tpulls[it.index] = it.pulls;
        written[it.index] = 1;
        return;
      end
      n = active();
      for (int i = 0; i < n; i++) begin
        sx = 0;
        sy = 0;
        if (tpulled[i])
          for (int j = 0; j < n; j++)
            if (j != i && tpulls[j]) pull(i, j, sx, sy);
        nvx[i] = sat32(longint'(signed'(tvx[i])) + sx);
        nvy[i] = sat32(longint'(signed'(tvy[i])) + sy);
      end
      for (int i = 0; i < n; i++) begin
        tvx[i] = nvx[i];
        tvy[i] = nvy[i];
        tpx[i] = sat32(longint'(signed'(tpx[i])) + longint'(signed'(nvx[i])));
        tpy[i] = sat32(longint'(signed'(tpy[i])) + longint'(signed'(nvy[i])));
        st.index = i[5:0];
        st.px = tpx[i];
        st.py = tpy[i];
        st.vx = tvx[i];
        st.vy = tvy[i];
        st.last = (i + 1 == n);
        pending = {pending, st};
      end
    endfunction

    function void check(body_state_t got);
      body_state_t exp_st;
      if (pending.size() == 0) begin
        $error("unexpected result transaction for index %0d", got.index);
        errors++;
        return;
      end
      exp_st = pending.pop_front();
      if (got.index !== exp_st.index) begin
        $error("out_index: expected %0d, got %0d", exp_st.index, got.index);
        errors++;
      end
      if (got.px !== exp_st.px) begin
        $error("new_pos_x: expected %h, got %h", exp_st.px, got.px);
        errors++;
      end
      if (got.py !== exp_st.py) begin
        $error("new_pos_y: expected %h, got %h", exp_st.py, got.py);
        errors++;
      end
      if (got.vx !== exp_st.vx) begin
        $error("new_vel_x: expected %h, got %h", exp_st.vx, got.vx);
        errors++;
      end
      if (got.vy !== exp_st.vy) begin
        $error("new_vel_y: expected %h, got %h", exp_st.vy, got.vy);
        errors++;
      end
      if (got.last !== exp_st.last) begin
        $error("last: expected %0d, got %0d", exp_st.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_stall;
  logic mode = 0;
  logic [5:0] body_index = 0;
  logic signed [31:0] pos_x = 0, pos_y = 0, vel_x = 0, vel_y = 0;
  logic [31:0] mass = 0;
  logic pulled_flag = 0, pulls_flag = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [5:0] out_index;
  logic signed [31:0] new_pos_x, new_pos_y, new_vel_x, new_vel_y;
  logic last;

  gravity_scoreboard sb = new();
  longint cycles = 0;
  int stall_style = 0;
  int stall_left = 0;
  int burst_left = 0;
  localparam longint CYCLE_LIMIT = 20000000;

  nbody_gravity_step uut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("nbody_gravity_step regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    body_state_t got;
    if (!rst && out_valid && !out_stall) begin
      got.index = out_index;
      got.px = new_pos_x;
      got.py = new_pos_y;
      got.vx = new_vel_x;
      got.vy = new_vel_y;
      got.last = last;
      sb.check(got);
    end
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 300);
    end else begin
      stall_left--;
    end
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= (stall_left % 40) < 25;
    endcase
  end

  task automatic write_reg(int addr, logic [31:0] value);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= 3'(addr * 4);
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    sb.set_reg(addr, value);
  endtask

  task automatic wait_idle();
    while (sb.pending.size() != 0) @(posedge clk);
    @(posedge clk);
    in_valid <= 0;
    repeat (20) @(posedge clk);
  endtask

  task automatic send(body_item_t it);
    if (burst_left == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 8);
    end
    @(posedge clk);
    in_valid <= 1;
    mode <= it.mode;
    body_index <= it.index;
    pos_x <= it.px;
    pos_y <= it.py;
    vel_x <= it.vx;
    vel_y <= it.vy;
    mass <= it.mass;
    pulled_flag <= it.pulled;
    pulls_flag <= it.pulls;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
    burst_left--;
    in_valid <= 0;
  endtask

  function automatic logic [31:0] rand_coord(bit near);
    if (near) return 32'($urandom_range(0, 32'h00400000)) - 32'h00200000;
    return $urandom();
  endfunction

  function automatic body_item_t rand_body(logic [5:0] idx, bit near, int flag_odds);
    body_item_t it;
    it.mode = 0;
    it.index = idx;
    it.px = rand_coord(near);
    it.py = rand_coord(near);
    it.vx = rand_coord(1) >>> $urandom_range(0, 8);
    it.vy = rand_coord(1) >>> $urandom_range(0, 8);
    if ($urandom_range(0, 7) == 0) begin
      it.vx = $urandom();
      it.vy = $urandom();
    end
    case ($urandom_range(0, 4))
      0: it.mass = 0;
      1: it.mass = 32'hffffffff;
      2: it.mass = $urandom_range(1, 1000);
      default: it.mass = $urandom();
    endcase
    it.pulled = ($urandom_range(0, flag_odds - 1) == 0);
    it.pulls = ($urandom_range(0, flag_odds - 1) == 0);
    return it;
  endfunction

  function automatic body_item_t tick_item();
    body_item_t it;
    it = rand_body(6'($urandom_range(0, 63)), 0, 2);
    it.mode = 1;
    it.px = $urandom();
    it.py = $urandom();
    return it;
  endfunction

  function automatic body_item_t fixed_body(logic [5:0] idx, logic [31:0] px, logic [31:0] py,
                                            logic [31:0] m, logic fl);
    body_item_t it;
    it.mode = 0;
    it.index = idx;
    it.px = px;
    it.py = py;
    it.vx = 32'h7fffffff;
    it.vy = 32'h80000000;
    it.mass = m;
    it.pulled = fl;
    it.pulls = 1;
    return it;
  endfunction

  initial begin
    int n;
    repeat (9) @(posedge clk);
    rst <= 0;
    repeat (2) @(posedge clk);

    // Directed: extremes of position and mass, zero distance, flags.
    write_reg(int'(REG_BODY_COUNT), 0);
    send(tick_item());
    wait_idle();
    send(fixed_body(0, 32'h7fffffff, 32'h7fffffff, 32'hffffffff, 1));
    send(fixed_body(1, 32'h80000000, 32'h80000000, 1, 1));
    send(fixed_body(2, 32'h00010000, 32'hffff0000, 0, 1));
    send(fixed_body(3, 32'h00010000, 32'hffff0000, 32'hffffffff, 0));
    send(fixed_body(4, 32'h00000000, 32'h00000001, 32'h12345678, 1));
    send(fixed_body(63, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1));
    wait_idle();
    write_reg(int'(REG_BODY_COUNT), 5);
    write_reg(int'(REG_GRAV_CONST), 32'hffffffff);
    send(tick_item());
    send(tick_item());
    wait_idle();
    write_reg(int'(REG_GRAV_CONST), 0);
    send(tick_item());
    wait_idle();
    write_reg(int'(REG_BODY_COUNT), 1);
    write_reg(int'(REG_GRAV_CONST), 1);
    send(tick_item());
    wait_idle();

    // Random phases: fill the active entries, add stray writes, then tick.
    for (int phase = 0; phase < 9; phase++) begin
      wait_idle();
      n = $urandom_range(2, 5);
      write_reg(int'(REG_BODY_COUNT), n);
      case ($urandom_range(0, 3))
        0: write_reg(int'(REG_GRAV_CONST), 32'hffffffff);
        1: write_reg(int'(REG_GRAV_CONST), $urandom_range(0, 32'h01000000));
        default: write_reg(int'(REG_GRAV_CONST), $urandom());
      endcase
      for (int i = 0; i < n; i++) send(rand_body(6'(i), $urandom_range(0, 3) != 0, 2));
      repeat ($urandom_range(0, 2)) send(rand_body(6'($urandom_range(0, 63)), 0, 2));
      repeat ($urandom_range(1, 3)) begin
        send(tick_item());
        if ($urandom_range(0, 2) == 0) send(rand_body(6'($urandom_range(0, n - 1)), 1, 2));
      end
    end

    // Count above the table size: every entry takes part, few interact.
    wait_idle();
    write_reg(int'(REG_BODY_COUNT), 127);
    write_reg(int'(REG_GRAV_CONST), $urandom());
    for (int i = 0; i < MAX_BODIES; i++) send(rand_body(6'(i), 1, 12));
    send(tick_item());
    wait_idle();
    write_reg(int'(REG_BODY_COUNT), 64);
    send(tick_item());

    wait_idle();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("nbody_gravity_step regression: pass");
    end else begin
      $display("nbody_gravity_step regression: fail");
    end
    $finish;
  end
endmodule
